// File: hw/rtl/gravity_body_interaction_step_assert.svh
// Assertion macros for the gravity step block.
`ifndef GRAVITY_BODY_INTERACTION_STEP_ASSERT_SVH
`define GRAVITY_BODY_INTERACTION_STEP_ASSERT_SVH

// Same-cycle implication.
`define GBIS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GBIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/gbis_pkg.sv
package gbis_pkg;
	localparam int FRAC_BITS = 16;

	localparam logic [31:0] GRAV_RESET   = 32'd4294967;
	localparam logic [30:0] RADIUS_RESET = 31'd327680;
	localparam logic [63:0] T1_MAX       = (64'd1 << 39) - 64'd1;

	localparam logic REG_GRAV   = 1'b0;
	localparam logic REG_RADIUS = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD     = 2'd0,
		CMD_SOURCE   = 2'd1,
		CMD_PARTICLE = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_SQX, S_SQY, S_RR, S_HIT, S_SQRT, S_MM, S_MMS, S_GMM,
		S_T1S, S_T1W, S_T2S, S_T2W, S_DXM, S_DXS, S_DXW, S_DYM, S_DYS, S_DYW,
		S_COLL, S_BXM, S_BXS, S_BXW, S_BYM, S_BYS, S_BYW, S_MASS, S_FIN, S_EMIT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic [63:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic        busy;
		logic [31:0] root;
	} sqrt_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -34'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction
endpackage

// File: hw/rtl/gravity_body_interaction_step.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// config   | cfg_we              | cfg_index, cfg_data
// input    | in_valid / in_stall | cmd, body_x/y, body_vx/vy, body_mass, last_body
// output   | out_valid/out_stall | absorbed, new_x/y, new_vx/vy, new_mass, done_res
//
// One item at a time. A load or unused command goes straight to the hand-off;
// a source or particle at zero distance skips the square root and the pull.
// Any other source or particle uses the square root and four divisions on the
// shared divider; a merge adds two more divisions unless both masses are zero.
// Reset clears the particle state and loads the register defaults.
// The result sits in an output register: the next item is taken while it
// waits on out_stall; only the final hand-off stage waits for it.
`include "gravity_body_interaction_step_assert.svh"

module gravity_body_interaction_step import gbis_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] body_x,
	input  logic signed [31:0] body_y,
	input  logic signed [31:0] body_vx,
	input  logic signed [31:0] body_vy,
	input  logic [31:0]        body_mass,
	input  logic               last_body,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               absorbed,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [31:0] new_vx,
	output logic signed [31:0] new_vy,
	output logic [31:0]        new_mass,
	output logic               done_res
);
	state_t state_q, state_nx;

	// configuration
	logic [31:0] grav_q;
	logic [30:0] radius_q;

	// particle state
	logic signed [31:0] own_x_q, own_y_q, own_vx_q, own_vy_q;
	logic [31:0]        own_mass_q;

	// held item
	cmd_t               cmd_q;
	logic signed [31:0] bx_q, by_q, bvx_q, bvy_q;
	logic [31:0]        bm_q;
	logic               last_q;

	// working registers
	logic signed [31:0] dx_q, dy_q;
	logic [63:0]        s2_q, prod_q;
	logic               hit_q;
	logic [31:0]        s_q, mm_q, t2_q;
	logic [38:0]        t1_q;
	logic [32:0]        tot_q;
	logic               absorbed_q;
	logic               out_valid_q;

	// shared units
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	logic [31:0]        ax, ay;
	logic signed [32:0] dfx, dfy;
	logic [31:0]        mdfx, mdfy;
	logic [63:0]        mm_wide;
	logic               out_free;
	logic               div_wait;

	gbis_isqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));
	gbis_div   u_div  (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	always_comb begin
		ax      = dx_q[31] ? 32'(-dx_q) : 32'(dx_q);
		ay      = dy_q[31] ? 32'(-dy_q) : 32'(dy_q);
		dfx     = 33'(bvx_q) - 33'(own_vx_q);
		dfy     = 33'(bvy_q) - 33'(own_vy_q);
		mdfx    = dfx[32] ? 32'(-dfx) : dfx[31:0];
		mdfy    = dfy[32] ? 32'(-dfy) : dfy[31:0];
		mm_wide = prod_q >> FRAC_BITS;
		out_free = !out_valid_q || !out_stall;
		mul_p   = 64'(mul_a) * 64'(mul_b);
		div_wait = (state_q == S_T1W) || (state_q == S_T2W) || (state_q == S_DXW) ||
			(state_q == S_DYW) || (state_q == S_BXW) || (state_q == S_BYW);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_nx = S_START;
			S_START: state_nx = (cmd_q == CMD_LOAD || cmd_q == CMD_NONE) ? S_FIN : S_SQX;
			S_SQX:   state_nx = S_SQY;
			S_SQY:   state_nx = S_RR;
			S_RR:    state_nx = S_HIT;
			S_HIT:   state_nx = (s2_q == 64'd0) ? S_COLL : S_SQRT;
			S_SQRT:  if (!sqrt_rsp.busy) state_nx = S_MM;
			S_MM:    state_nx = S_MMS;
			S_MMS:   state_nx = S_GMM;
			S_GMM:   state_nx = S_T1S;
			S_T1S:   state_nx = S_T1W;
			S_T1W:   if (!div_rsp.busy) state_nx = S_T2S;
			S_T2S:   state_nx = S_T2W;
			S_T2W:   if (!div_rsp.busy) state_nx = S_DXM;
			S_DXM:   state_nx = S_DXS;
			S_DXS:   state_nx = S_DXW;
			S_DXW:   if (!div_rsp.busy) state_nx = S_DYM;
			S_DYM:   state_nx = S_DYS;
			S_DYS:   state_nx = S_DYW;
			S_DYW:   if (!div_rsp.busy) state_nx = S_COLL;
			S_COLL: begin
				if (hit_q && cmd_q == CMD_PARTICLE)
					state_nx = (own_mass_q == 32'd0 && bm_q == 32'd0) ? S_MASS : S_BXM;
				else
					state_nx = S_FIN;
			end
			S_BXM:   state_nx = S_BXS;
			S_BXS:   state_nx = S_BXW;
			S_BXW:   if (!div_rsp.busy) state_nx = S_BYM;
			S_BYM:   state_nx = S_BYS;
			S_BYS:   state_nx = S_BYW;
			S_BYW:   if (!div_rsp.busy) state_nx = S_MASS;
			S_MASS:  state_nx = S_FIN;
			S_FIN:   state_nx = S_EMIT;
			S_EMIT:  if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// unit controls and multiplier operands
	always_comb begin
		in_stall          = (state_q != S_IDLE);
		sqrt_req.start    = (state_q == S_HIT) && (s2_q != 64'd0);
		sqrt_req.radicand = s2_q;
		div_req.start     = 1'b0;
		div_req.dividend  = prod_q;
		div_req.divisor   = {1'b0, s_q};
		mul_a             = ax;
		mul_b             = ax;
		case (state_q)
			S_SQY: begin
				mul_a = ay;
				mul_b = ay;
			end
			S_RR: begin
				mul_a = {1'b0, radius_q};
				mul_b = {1'b0, radius_q};
			end
			S_MM: begin
				mul_a = own_mass_q;
				mul_b = bm_q;
			end
			S_GMM: begin
				mul_a = grav_q;
				mul_b = mm_q;
			end
			S_DXM: begin
				mul_a = t2_q;
				mul_b = ax;
			end
			S_DYM: begin
				mul_a = t2_q;
				mul_b = ay;
			end
			S_BXM: begin
				mul_a = bm_q;
				mul_b = mdfx;
			end
			S_BYM: begin
				mul_a = bm_q;
				mul_b = mdfy;
			end
			S_T1S: begin
				div_req.start    = 1'b1;
				div_req.dividend = 64'(prod_q[63:32]) << FRAC_BITS;
			end
			S_T2S: begin
				div_req.start    = 1'b1;
				div_req.dividend = 64'(t1_q) << FRAC_BITS;
			end
			S_DXS, S_DYS: div_req.start = 1'b1;
			S_BXS, S_BYS: begin
				div_req.start   = 1'b1;
				div_req.divisor = tot_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q   <= GRAV_RESET;
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRAV:   grav_q   <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// output valid: set on hand-off, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// particle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_x_q     <= '0;
			own_y_q     <= '0;
			own_vx_q    <= '0;
			own_vy_q    <= '0;
			own_mass_q  <= '0;
		end else begin
			case (state_q)
				S_START: begin
					if (cmd_q == CMD_LOAD) begin
						own_x_q    <= bx_q;
						own_y_q    <= by_q;
						own_vx_q   <= bvx_q;
						own_vy_q   <= bvy_q;
						own_mass_q <= bm_q;
					end
				end
				// apply the pull, sign follows the displacement
				S_DXW: if (!div_rsp.busy) own_vx_q <= sat32(dx_q[31] ?
					34'(own_vx_q) - 34'(div_rsp.quot[32:0]) :
					34'(own_vx_q) + 34'(div_rsp.quot[32:0]));
				S_DYW: if (!div_rsp.busy) own_vy_q <= sat32(dy_q[31] ?
					34'(own_vy_q) - 34'(div_rsp.quot[32:0]) :
					34'(own_vy_q) + 34'(div_rsp.quot[32:0]));
				S_COLL: begin
					if (hit_q && cmd_q == CMD_SOURCE) begin
						own_vx_q <= '0;
						own_vy_q <= '0;
					end
				end
				// merge: move toward the other velocity by the mass share
				S_BXW: if (!div_rsp.busy) own_vx_q <= dfx[32] ?
					own_vx_q - div_rsp.quot[31:0] : own_vx_q + div_rsp.quot[31:0];
				S_BYW: if (!div_rsp.busy) own_vy_q <= dfy[32] ?
					own_vy_q - div_rsp.quot[31:0] : own_vy_q + div_rsp.quot[31:0];
				S_MASS: own_mass_q <= tot_q[32] ? 32'hffffffff : tot_q[31:0];
				S_FIN: begin
					if (last_q) begin
						own_x_q <= sat32(34'(own_x_q) + 34'(own_vx_q));
						own_y_q <= sat32(34'(own_y_q) + 34'(own_vy_q));
					end
				end
				default: ;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q  <= cmd_t'(cmd);
					bx_q   <= body_x;
					by_q   <= body_y;
					bvx_q  <= body_vx;
					bvy_q  <= body_vy;
					bm_q   <= body_mass;
					last_q <= last_body;
				end
			end
			S_START: begin
				absorbed_q <= 1'b0;
				dx_q <= sat32(34'(bx_q) - 34'(own_x_q));
				dy_q <= sat32(34'(by_q) - 34'(own_y_q));
			end
			S_SQX: prod_q <= mul_p;
			S_SQY: s2_q   <= prod_q + mul_p;
			S_RR:  prod_q <= mul_p;
			S_HIT: hit_q  <= s2_q <= prod_q;
			S_SQRT: if (!sqrt_rsp.busy) s_q <= sqrt_rsp.root;
			S_MM:  prod_q <= mul_p;
			S_MMS: mm_q   <= (|mm_wide[63:32]) ? 32'hffffffff : mm_wide[31:0];
			S_GMM: prod_q <= mul_p;
			S_T1W: if (!div_rsp.busy)
				t1_q <= (div_rsp.quot > T1_MAX) ? T1_MAX[38:0] : div_rsp.quot[38:0];
			S_T2W: if (!div_rsp.busy)
				t2_q <= (|div_rsp.quot[63:32]) ? 32'hffffffff : div_rsp.quot[31:0];
			S_DXM, S_DYM, S_BXM, S_BYM: prod_q <= mul_p;
			S_COLL: tot_q <= 33'(own_mass_q) + 33'(bm_q);
			S_MASS: absorbed_q <= 1'b1;
			S_EMIT: begin
				if (out_free) begin
					absorbed <= absorbed_q;
					new_x    <= own_x_q;
					new_y    <= own_y_q;
					new_vx   <= own_vx_q;
					new_vy   <= own_vy_q;
					new_mass <= own_mass_q;
					done_res <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`GBIS_ASSERT_HOLDS(a_sqrt_owner, clk, arst_n, sqrt_rsp.busy, state_q == S_SQRT, "sqrt busy outside its wait state")
	`GBIS_ASSERT_HOLDS(a_div_owner, clk, arst_n, div_rsp.busy, div_wait, "divider busy outside a wait state")
	`GBIS_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && !in_stall, in_stall, "second item taken while one is at work")
endmodule

// File: hw/rtl/gbis_div.sv
// Restoring divider, one quotient bit per cycle, for a 64-bit quotient.
module gbis_div import gbis_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] rem_sh;
	logic [33:0] rem_nx;
	logic        ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[63]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= rem_nx[32:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = quo_q;
endmodule

// File: hw/rtl/gbis_isqrt.sv
// Integer square root, one result bit per cycle, for a 32-bit root.
module gbis_isqrt import gbis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);
	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [63:0] trial;
	logic        ge;

	always_comb begin
		trial = res_q + bit_q;
		ge    = n_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.radicand;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (ge) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.root = res_q[31:0];
endmodule

// File: tb/sv/gravity_body_interaction_step_tb.sv
module gravity_body_interaction_step_tb import gbis_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 1500;
	localparam int HOLD_LEN = 3000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] bx, by, bvx, bvy, bm;
		logic        last;
	} body_t;

	typedef struct packed {
		logic        absorbed;
		logic [31:0] x, y, vx, vy, mass;
		logic        done;
	} own_t;

	// one row of the directed table: the item, and optionally its typed-in result
	typedef struct {
		body_t b;
		bit    has_exp;
		own_t  e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_GRAV;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_LOAD;
	logic signed [31:0] body_x = '0, body_y = '0, body_vx = '0, body_vy = '0;
	logic [31:0] body_mass = '0;
	logic last_body = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic absorbed;
	logic signed [31:0] new_x, new_y, new_vx, new_vy;
	logic [31:0] new_mass;
	logic done_res;

	gravity_body_interaction_step dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [31:0] g_const;
	logic [30:0] c_radius;
	longint p_x, p_y, p_vx, p_vy;
	longint unsigned p_mass;

	own_t expected_q[$];
	int errors = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 0;
	int hold_cycles = 0;
	int quiet = 0;

	function automatic longint sat32l(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint blend_vel(longint v1, longint v2, longint unsigned m2,
			longint unsigned tot);
		longint d = v2 - v1;
		longint off;
		off = longint'(m2 * magn(d) / tot);
		return d < 0 ? v1 - off : v1 + off;
	endfunction

	// advance the own particle by one item, return the result it yields
	function automatic own_t advance_particle(body_t b);
		own_t r;
		longint bx, by, dx, dy, dvx, dvy;
		longint unsigned s2, s, mm, gmm, t1, t2, tot, rr;
		bit hit;
		bx = longint'($signed(b.bx));
		by = longint'($signed(b.by));
		r.absorbed = 0;
		if (b.cmd == CMD_LOAD) begin
			p_x = bx; p_y = by;
			p_vx = longint'($signed(b.bvx));
			p_vy = longint'($signed(b.bvy));
			p_mass = b.bm;
		end else if (b.cmd == CMD_SOURCE || b.cmd == CMD_PARTICLE) begin
			dx = sat32l(bx - p_x);
			dy = sat32l(by - p_y);
			s2 = magn(dx) * magn(dx) + magn(dy) * magn(dy);
			rr = longint'(c_radius) * longint'(c_radius);
			hit = s2 <= rr;
			if (s2 != 0) begin
				s = int_sqrt(s2);
				mm = (p_mass * longint'(b.bm)) >> FB;
				if (mm > 64'hFFFFFFFF) mm = 64'hFFFFFFFF;
				gmm = (longint'(g_const) * mm) >> 32;
				t1 = (gmm << FB) / s;
				if (t1 > T1_MAX) t1 = T1_MAX;
				t2 = (t1 << FB) / s;
				if (t2 > 64'hFFFFFFFF) t2 = 64'hFFFFFFFF;
				dvx = longint'(t2 * magn(dx) / s);
				dvy = longint'(t2 * magn(dy) / s);
				p_vx = sat32l(dx < 0 ? p_vx - dvx : p_vx + dvx);
				p_vy = sat32l(dy < 0 ? p_vy - dvy : p_vy + dvy);
			end
			if (hit && b.cmd == CMD_SOURCE) begin
				p_vx = 0;
				p_vy = 0;
			end else if (hit) begin
				tot = p_mass + longint'(b.bm);
				if (tot != 0) begin
					p_vx = blend_vel(p_vx, longint'($signed(b.bvx)), b.bm, tot);
					p_vy = blend_vel(p_vy, longint'($signed(b.bvy)), b.bm, tot);
				end
				p_mass = tot > 64'hFFFFFFFF ? 64'hFFFFFFFF : tot;
				r.absorbed = 1;
			end
		end
		if (b.last) begin
			p_x = sat32l(p_x + p_vx);
			p_y = sat32l(p_y + p_vy);
		end
		r.x = p_x[31:0]; r.y = p_y[31:0];
		r.vx = p_vx[31:0]; r.vy = p_vy[31:0];
		r.mass = p_mass[31:0];
		r.done = b.last;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		own_t e;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", new_x, 0);
			end else begin
				e = expected_q.pop_front();
				if (absorbed !== e.absorbed) report_mismatch("absorbed", absorbed, e.absorbed);
				if (new_x !== e.x) report_mismatch("new_x", new_x, e.x);
				if (new_y !== e.y) report_mismatch("new_y", new_y, e.y);
				if (new_vx !== e.vx) report_mismatch("new_vx", new_vx, e.vx);
				if (new_vy !== e.vy) report_mismatch("new_vy", new_vy, e.vy);
				if (new_mass !== e.mass) report_mismatch("new_mass", new_mass, e.mass);
				if (done_res !== e.done) report_mismatch("done_res", done_res, e.done);
			end
		end
	end

	// receiver: random stall, or one long hold-off counted here
	always @(posedge clk) begin
		if (hold_off && hold_cycles < HOLD_LEN) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog: count cycles in which nothing is accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// offer one item, hold it until accepted, predict at acceptance
	task automatic send_item(body_t b, bit has_exp, own_t e);
		own_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= b.cmd;
		body_x <= b.bx; body_y <= b.by;
		body_vx <= b.bvx; body_vy <= b.bvy;
		body_mass <= b.bm;
		last_body <= b.last;
		do @(posedge clk); while (in_stall);
		p = advance_particle(b);
		if (has_exp && p != e)
			report_mismatch("directed row against prediction", p.x, e.x);
		expected_q = {expected_q, has_exp ? e : p};
	endtask

	// write both registers on consecutive edges
	task automatic write_regs(logic [31:0] g, logic [31:0] rad);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRAV;
		cfg_data <= g;
		@(posedge clk);
		g_const = g;
		cfg_index <= REG_RADIUS;
		cfg_data <= rad;
		@(posedge clk);
		c_radius = rad[30:0];
		cfg_we <= 1'b0;
	endtask

	// drop the input, drain, then let a load or source finish before touching the registers
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_pos(int spread);
		case ($urandom_range(3))
			0: return $urandom();
			default: return $signed($urandom_range(2 * spread)) - spread;
		endcase
	endfunction

	function automatic body_t rand_body(bit frame_end);
		body_t b;
		int r = $urandom_range(99);
		b.cmd = r < 45 ? CMD_PARTICLE : r < 85 ? CMD_SOURCE : r < 97 ? CMD_LOAD : CMD_NONE;
		b.bx = rand_pos(32'h0010_0000);
		b.by = rand_pos(32'h0010_0000);
		b.bvx = $urandom_range(3) == 0 ? $urandom() : rand_pos(32'h0002_0000);
		b.bvy = $urandom_range(3) == 0 ? $urandom() : rand_pos(32'h0002_0000);
		b.bm = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0100_0000);
		b.last = frame_end;
		return b;
	endfunction

	row_t rows[$];
	own_t nil;

	function automatic row_t mk(logic [1:0] c, logic [31:0] x, logic [31:0] y,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] m, logic l);
		row_t r;
		r.b = '{c, x, y, vx, vy, m, l};
		r.has_exp = 0;
		r.e = '{0, 0, 0, 0, 0, 0, 0};
		return r;
	endfunction

	function automatic row_t mk_exp(row_t r, own_t e);
		r.has_exp = 1;
		r.e = e;
		return r;
	endfunction

	function automatic void add_row(row_t r);
		rows = {rows, r};
	endfunction

	initial begin
		body_t b;
		int n;
		nil = '{0, 0, 0, 0, 0, 0, 0};
		g_const = GRAV_RESET;
		c_radius = RADIUS_RESET;
		p_x = 0; p_y = 0; p_vx = 0; p_vy = 0; p_mass = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, extremes, saturation, every command and special case
		add_row(mk_exp(mk(CMD_NONE, 0, 0, 0, 0, 0, 0), nil));
		add_row(mk_exp(mk(CMD_SOURCE, 0, 0, 0, 0, 0, 1), '{0, 0, 0, 0, 0, 0, 1}));
		add_row(mk_exp(mk(CMD_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'hffffffff, 1),
			'{0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1}));
		add_row(mk(CMD_SOURCE, 32'h80000000, 32'h7fffffff, 0, 0, 32'hffffffff, 0));
		add_row(mk(CMD_PARTICLE, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'hffffffff, 0));
		add_row(mk(CMD_LOAD, 0, 0, 0, 0, 0, 0));
		add_row(mk(CMD_PARTICLE, 0, 0, 32'h00010000, 32'hffff0000, 0, 0));
		add_row(mk(CMD_LOAD, 0, 0, 32'h00030000, 32'hfffd0000, 32'h00010000, 0));
		add_row(mk(CMD_PARTICLE, 32'h00010000, 0, 32'hffff0000, 32'h00050000,
			32'h00030000, 0));
		add_row(mk(CMD_SOURCE, 0, 32'h00020000, 32'h12345678, 0, 32'h00100000, 1));
		add_row(mk(CMD_LOAD, 0, 0, 32'h00010000, 0, 32'h01000000, 0));
		add_row(mk(CMD_SOURCE, 32'h00500000, 32'hffb00000, 0, 0, 32'h01000000, 0));
		add_row(mk(CMD_PARTICLE, 32'h00000001, 0, 0, 0, 32'h00000001, 0));
		add_row(mk(CMD_PARTICLE, 32'h00050000, 0, 0, 0, 32'h00010000, 0));
		add_row(mk(CMD_PARTICLE, 32'h00050001, 0, 0, 0, 32'h00010000, 1));
		add_row(mk(CMD_NONE, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
			32'haaaaaaaa, 32'h55555555, 1));
		add_row(mk(CMD_LOAD, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
			32'h55555555, 32'haaaaaaaa, 0));
		add_row(mk(CMD_PARTICLE, 32'haaaaaaab, 32'h55555555, 32'h7fffffff,
			32'h80000000, 32'hffffffff, 1));
		foreach (rows[i]) send_item(rows[i].b, rows[i].has_exp, rows[i].e);
		settle();

		// random phases over register settings, extremes among them
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_regs(32'hffffffff, 32'h7fffffff);
				1: write_regs(0, 0);
				2: write_regs(GRAV_RESET, 32'(RADIUS_RESET));
				default: write_regs($urandom(), $urandom_range(32'h0040_0000));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			// long receiver hold-off while items keep coming
			if (ph == 2) hold_off <= 1'b1;
			n = 0;
			while (n < N_RANDOM / 6) begin
				// well-formed frame: a load, then bodies, last flagged
				b = rand_body(0);
				b.cmd = CMD_LOAD;
				send_item(b, 0, nil);
				n++;
				for (int k = $urandom_range(1, 6); k > 0; k--) begin
					b = rand_body(k == 1 || $urandom_range(15) == 0);
					// often a body near the particle, to exercise collisions
					if ($urandom_range(2) == 0) begin
						b.bx = p_x[31:0] + $signed($urandom_range(32'h000a_0000)) - 32'sh0005_0000;
						b.by = p_y[31:0] + $signed($urandom_range(32'h000a_0000)) - 32'sh0005_0000;
					end
					send_item(b, 0, nil);
					n++;
				end
			end
			settle();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
